// ===== src/ptmw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptmw_pkg
// Shared constants and types for the page table map and walk core.
// ----------------------------------------------------------------------------
package ptmw_pkg;

	localparam int TableSlots    = 64;
	localparam int EntriesPerTbl = 512;
	localparam int SlotW         = $clog2(TableSlots);
	localparam int IdxW          = 9;
	localparam int AddrW         = SlotW + IdxW;
	localparam int FrameW        = 36;

	localparam logic [1:0] OP_MAP2M = 2'd0;
	localparam logic [1:0] OP_MAP4K = 2'd1;
	localparam logic [1:0] OP_LOOK  = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_REPL    = 3'd1;
	localparam logic [2:0] ST_BLOCK   = 3'd2;
	localparam logic [2:0] ST_POOLOUT = 3'd3;
	localparam logic [2:0] ST_MISS1   = 3'd4;

	localparam logic [63:0] DESC_AF   = 64'h400;
	localparam logic [63:0] DESC_SH   = 64'h300;
	localparam logic [63:0] DESC_UXN  = 64'h0040_0000_0000_0000;
	localparam logic [63:0] ADDR_MASK = 64'h0000_FFFF_FFFF_F000;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] entry;
		logic        is_block;
	} res_t;

endpackage

// ===== src/ptmw_if.sv =====
// ----------------------------------------------------------------------------
// ptmw_req_if / ptmw_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ptmw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [47:0] va;
	logic [47:0] pa;
	logic [2:0]  attr_sel;
	logic [1:0]  privilege;
	modport source (output valid, op, va, pa, attr_sel, privilege, input ready);
	modport sink   (input valid, op, va, pa, attr_sel, privilege, output ready);
endinterface

interface ptmw_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] entry;
	logic        is_block;
	modport source (output valid, status, entry, is_block, input ready);
	modport sink   (input valid, status, entry, is_block, output ready);
endinterface

// ===== src/page_table_map_and_walk_core.sv =====
// ----------------------------------------------------------------------------
// page_table_map_and_walk_core
// Four-level page table builder and walker over a pool of table slots.
// ----------------------------------------------------------------------------
// One request at a time; a new request is taken only once the previous result
// has been transferred. Each level is handled by a read state then an evaluate
// state on the single-port descriptor RAM (one address a cycle). A map that
// meets an empty entry allocates a table from the pool: all 512 entries are
// cleared, the parent entry is linked to it, and the link is read back. After
// reset the root table is cleared, and no request is taken during that pass.
module page_table_map_and_walk_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [35:0] cfg_wdata,
	ptmw_req_if.sink    req,
	ptmw_res_if.source  res
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b00_0001,
		S_IDLE = 6'b00_0010,
		S_RD   = 6'b00_0100,
		S_EVAL = 6'b00_1000,
		S_FILL = 6'b01_0000,
		S_LINK = 6'b10_0000
	} state_t;

	state_t state_q;
	logic [35:0] pool_q;
	logic [ptmw_pkg::SlotW:0] next_q;
	logic [ptmw_pkg::IdxW:0] clr_q;
	logic [ptmw_pkg::SlotW-1:0] slot_q, clr_slot_q;
	logic [1:0] lvl_q;
	logic [1:0] op_q, priv_q;
	logic [47:0] va_q, pa_q;
	logic [2:0] attr_q;
	ptmw_pkg::res_t res_q, res_d;
	logic res_v_q;

	// descriptor RAM
	logic [63:0] mem [ptmw_pkg::TableSlots*ptmw_pkg::EntriesPerTbl];
	logic [63:0] rdata_q;
	logic mwe;
	logic [ptmw_pkg::AddrW-1:0] maddr;
	logic [63:0] mwdata;

	always_ff @(posedge clk) begin
		if (mwe)
			mem[maddr] <= mwdata;
		rdata_q <= mem[maddr];
	end

	// index of the current level, then position
	logic [ptmw_pkg::IdxW-1:0] idx;
	logic [ptmw_pkg::AddrW-1:0] pos;
	always_comb begin
		unique case (lvl_q)
			2'd0: idx = va_q[47:39];
			2'd1: idx = va_q[38:30];
			2'd2: idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end
	assign pos = {slot_q, idx};

	// pointer to slot translation
	logic [35:0] dslot;
	logic in_pool;
	assign dslot = rdata_q[47:12] - pool_q;
	assign in_pool = dslot < 36'(ptmw_pkg::TableSlots);

	// descriptor to write at the final level
	logic [63:0] blk_desc, page_desc;
	logic [1:0] ap;
	always_comb begin
		unique case (priv_q)
			2'd0: ap = 2'b01;
			2'd1: ap = 2'b00;
			2'd2: ap = 2'b10;
			default: ap = 2'b11;
		endcase
	end
	assign blk_desc = ({16'd0, pa_q} & ptmw_pkg::ADDR_MASK) | ptmw_pkg::DESC_AF |
		ptmw_pkg::DESC_SH | {59'd0, attr_q, 2'b01};
	assign page_desc = ({16'd0, pa_q} & ptmw_pkg::ADDR_MASK) |
		((priv_q == 2'd1) ? ptmw_pkg::DESC_UXN : 64'd0) | ptmw_pkg::DESC_AF |
		ptmw_pkg::DESC_SH | {56'd0, ap, 1'b0, attr_q, 2'b11};

	logic [35:0] new_frame;
	assign new_frame = pool_q + 36'(clr_slot_q);
	logic is_map;
	assign is_map = (op_q == ptmw_pkg::OP_MAP2M) || (op_q == ptmw_pkg::OP_MAP4K);

	// request transfer only when idle and the result register is empty
	logic accept;
	assign req.ready = (state_q == S_IDLE) && !res_v_q;
	assign accept = req.valid && req.ready;

	// memory port and next-state
	state_t state_d;
	logic done;
	always_comb begin
		mwe = 1'b0;
		maddr = pos;
		mwdata = 64'd0;
		state_d = state_q;
		done = 1'b0;
		res_d = '0;
		unique case (state_q)
			S_CLR, S_FILL: begin
				mwe = 1'b1;
				maddr = {clr_slot_q, clr_q[ptmw_pkg::IdxW-1:0]};
				if (clr_q == (ptmw_pkg::IdxW+1)'(ptmw_pkg::EntriesPerTbl - 1))
					state_d = (state_q == S_CLR) ? S_IDLE : S_LINK;
			end
			S_IDLE: begin
				if (accept)
					state_d = S_RD;
			end
			S_RD: begin
				state_d = S_EVAL;
				if (op_q == ptmw_pkg::OP_MAP2M && lvl_q == 2'd2) begin
					mwe = 1'b1;
					mwdata = blk_desc;
					res_d = '{ptmw_pkg::ST_OK, blk_desc, 1'b1};
					done = 1'b1;
				end else if (!is_map && op_q != ptmw_pkg::OP_LOOK) begin
					done = 1'b1;
				end
			end
			S_EVAL: begin
				state_d = S_RD;
				if (is_map) begin
					if (op_q == ptmw_pkg::OP_MAP4K && lvl_q == 2'd3) begin
						mwe = 1'b1;
						mwdata = page_desc;
						res_d = '{rdata_q[0] ? ptmw_pkg::ST_REPL : ptmw_pkg::ST_OK,
							page_desc, 1'b0};
						done = 1'b1;
					end else if (lvl_q == 2'd2 && rdata_q[1:0] == 2'b01) begin
						res_d = '{ptmw_pkg::ST_BLOCK, rdata_q, 1'b1};
						done = 1'b1;
					end else if (!rdata_q[0]) begin
						if (next_q >= (ptmw_pkg::SlotW+1)'(ptmw_pkg::TableSlots)) begin
							res_d = '{ptmw_pkg::ST_POOLOUT, 64'd0, 1'b0};
							done = 1'b1;
						end else
							state_d = S_FILL;
					end else if (!in_pool) begin
						res_d = '{ptmw_pkg::ST_POOLOUT, 64'd0, 1'b0};
						done = 1'b1;
					end
				end else begin
					if (!rdata_q[0]) begin
						res_d = '{ptmw_pkg::ST_MISS1 + {1'b0, lvl_q}, 64'd0, 1'b0};
						done = 1'b1;
					end else if (lvl_q == 2'd3) begin
						res_d = '{ptmw_pkg::ST_OK, rdata_q, 1'b0};
						done = 1'b1;
					end else if (lvl_q == 2'd2 && !rdata_q[1]) begin
						res_d = '{ptmw_pkg::ST_OK, rdata_q, 1'b1};
						done = 1'b1;
					end else if (!in_pool) begin
						res_d = '{ptmw_pkg::ST_MISS1 + {1'b0, lvl_q} + 3'd1, 64'd0, 1'b0};
						done = 1'b1;
					end
				end
			end
			S_LINK: begin
				mwe = 1'b1;
				mwdata = {16'd0, new_frame, 12'h003};
				state_d = S_RD;
			end
			default: state_d = S_IDLE;
		endcase
		if (done)
			state_d = S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			pool_q <= '0;
			next_q <= (ptmw_pkg::SlotW+1)'(1);
			clr_q <= '0;
			clr_slot_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
			slot_q <= '0;
			lvl_q <= '0;
		end else begin
			if (cfg_we)
				pool_q <= cfg_wdata;
			state_q <= state_d;
			if (state_q == S_CLR || state_q == S_FILL)
				clr_q <= clr_q + 1'b1;
			if (accept) begin
				slot_q <= '0;
				lvl_q <= '0;
			end
			if (state_q == S_EVAL && state_d == S_FILL) begin
				clr_slot_q <= next_q[ptmw_pkg::SlotW-1:0];
				next_q <= next_q + 1'b1;
				clr_q <= '0;
			end
			if (state_q == S_EVAL && state_d == S_RD) begin
				slot_q <= dslot[ptmw_pkg::SlotW-1:0];
				lvl_q <= lvl_q + 2'd1;
			end
			// result register: loaded on completion, freed on transfer
			if (done) begin
				res_q <= res_d;
				res_v_q <= 1'b1;
			end else if (res_v_q && res.ready)
				res_v_q <= 1'b0;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.op;
			va_q <= req.va;
			pa_q <= req.pa;
			attr_q <= req.attr_sel;
			priv_q <= req.privilege;
		end
	end

	assign res.valid = res_v_q;
	assign res.status = res_q.status;
	assign res.entry = res_q.entry;
	assign res.is_block = res_q.is_block;

endmodule
